### rtl/oal_pkg.sv
// Shared constants, codes and control types of the ordered array list engine.
`default_nettype none
package oal_pkg;

  localparam int CAPACITY  = 64;
  localparam int LEN_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 2;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 2;
  localparam int OUT_LEN_W = 7;
  localparam int CMP_W     = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
  localparam int LVL       = $clog2(CAPACITY);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BEYOND    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     capture;
  } cell_ctrl_t;

  typedef struct packed {
    logic             capture;
    logic             ins;
    logic             del;
    logic [LEN_W-1:0] at;
  } chain_cmd_t;

endpackage
`default_nettype wire

### rtl/oal_req_if.sv
// Request channel: action, position and value with valid/ready.
`default_nettype none
interface oal_req_if import oal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [POS_W-1:0]  position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface
`default_nettype wire

### rtl/oal_rsp_if.sv
// Response channel: status, list length and read data with valid/ready.
`default_nettype none
interface oal_rsp_if import oal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [OUT_LEN_W-1:0]     list_length;
  logic signed [DATA_W-1:0] read_data;

  modport source (output valid, output status, output list_length, output read_data,
                  input ready);
  modport sink   (input valid, input status, input list_length, input read_data,
                  output ready);
endinterface
`default_nettype wire

### rtl/oal_cell.sv
// One list slot: holds an entry, shifts from either neighbour, flags a match.
`default_nettype none
module oal_cell import oal_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  input  logic [DATA_W-1:0] value,
  input  logic              qualify,
  output logic [DATA_W-1:0] entry,
  output logic              match
);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD:  entry <= entry;
      CELL_LOAD:  entry <= value;
      CELL_LEFT:  entry <= left;
      CELL_RIGHT: entry <= right;
      default:    entry <= entry;
    endcase
    // only slots inside the list may match
    if (ctrl.capture) begin
      match <= qualify && (entry == value);
    end
  end

endmodule
`default_nettype wire

### rtl/oal_chain.sv
// Row of list cells with per-slot shift control, first-match prefix and read select.
`default_nettype none
module oal_chain import oal_pkg::*; (
  input  logic              clk,
  input  chain_cmd_t        cmd,
  input  logic [DATA_W-1:0] value,
  input  logic [LEN_W-1:0]  count,
  input  logic [LEN_W-1:0]  rd_idx,
  output logic              found,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0]   entry [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] pre [LVL+1];
  logic [DATA_W-1:0]   rd_sel;

  // parallel prefix OR: pre[LVL][i] set when some slot at or below i matched
  always_comb begin
    pre[0] = match;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  assign found = |match;

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_idx == LEN_W'(i)) begin
        rd_sel = rd_sel | entry[i];
      end
    end
  end

  // read data registered in the compare cycle; the row is still then
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= rd_sel;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    logic [LEN_W-1:0]  idx;

    assign idx = LEN_W'(g);

    if (g == 0) begin : g_first
      assign left = value;
    end else begin : g_left
      assign left = entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right = entry[g];
    end else begin : g_right
      assign right = entry[g+1];
    end

    always_comb begin
      ctrl.capture = cmd.capture;
      ctrl.op      = CELL_HOLD;
      if (cmd.ins) begin
        if (idx == cmd.at) begin
          ctrl.op = CELL_LOAD;
        end else if (idx > cmd.at) begin
          ctrl.op = CELL_LEFT;
        end
      end else if (cmd.del && pre[LVL][g]) begin
        ctrl.op = CELL_RIGHT;
      end
    end

    oal_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left    (left),
      .right   (right),
      .value   (value),
      .qualify (idx < count),
      .entry   (entry[g]),
      .match   (match[g])
    );
  end

endmodule
`default_nettype wire

### rtl/ordered_array_list_engine.sv
// Top level of the ordered array list engine: control, length and result register.
//
// Use: one transaction on req (action, position, value) gives exactly one
// transaction on rsp (status, list_length, read_data). Actions: insert at a
// position (negative position appends), delete the first entry equal to value,
// read the entry at a position. The list lives in a row of CAPACITY cells, each
// shifting from its neighbour, so inserts and deletes move all entries at once.
// A request taken into the request register is compare-captured in S_CMP, and
// its result is loaded into the response register when S_EXE commits, visible
// from then on. Each request passes the compare state (all cells matching
// against value) and then the shift/commit state. A new request is taken in
// the commit cycle itself while the response register is free.
// Reset (rst, synchronous, active high): list length to zero, no response
// pending. Entry contents are not cleared; slots beyond the length are unused.
// Receiver stall: the response register holds its transaction; a finished
// request waits in the commit cycle, with the list unchanged, until the
// register frees, and no new request is taken meanwhile.
`default_nettype none
module ordered_array_list_engine import oal_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  oal_req_if.sink   req,
  oal_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXE  = 3'b100
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [LEN_W-1:0]         count;
  logic [LEN_W-1:0]         count_next;
  action_t                  act_q;
  logic signed [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0]        val_q;

  logic                     ovalid;
  status_t                  status_q;
  logic [OUT_LEN_W-1:0]     len_q;
  logic [DATA_W-1:0]        data_q;

  logic                     slot_free;
  logic                     take;
  logic                     finish;
  logic                     found;
  logic [DATA_W-1:0]        rd_data;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic [LEN_W-1:0]         pos_low;
  logic [LEN_W-1:0]         at;
  logic                     beyond;
  logic                     full;
  logic                     rd_ok;
  status_t                  status_next;
  logic [DATA_W-1:0]        data_next;
  chain_cmd_t               cmd;

  // handshake
  assign slot_free = !ovalid || rsp.ready;
  assign req.ready = (state == S_IDLE) || ((state == S_EXE) && slot_free);
  assign take      = req.valid && req.ready;
  assign finish    = (state == S_EXE) && slot_free;

  // position checks, signed against the current length
  assign pos_ext = {{(CMP_W - POS_W){pos_q[POS_W-1]}}, pos_q};
  assign cnt_ext = {{(CMP_W - LEN_W){1'b0}}, count};
  assign beyond  = $signed(pos_ext) > $signed(cnt_ext);
  assign full    = (count == LEN_W'(CAPACITY));
  assign pos_low = LEN_W'(pos_q[POS_W-2:0]);
  assign at      = pos_q[POS_W-1] ? count : pos_low;
  assign rd_ok   = !pos_q[POS_W-1] && ($signed(pos_ext) < $signed(cnt_ext));

  always_comb begin
    status_next = ST_OK;
    data_next   = '0;
    count_next  = count;
    unique case (act_q)
      ACT_INSERT: begin
        if (beyond) begin
          status_next = ST_BEYOND;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + LEN_W'(1);
        end
      end
      ACT_DELETE: begin
        if (found) begin
          count_next = count - LEN_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      ACT_READ: begin
        if (rd_ok) begin
          data_next = rd_data;
        end else begin
          status_next = ST_BEYOND;
        end
      end
      ACT_NONE: begin
        status_next = ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // chain commands: compare in S_CMP, shift when the result commits
  always_comb begin
    cmd.capture = (state == S_CMP);
    cmd.ins     = finish && (act_q == ACT_INSERT) && !beyond && !full;
    cmd.del     = finish && (act_q == ACT_DELETE) && found;
    cmd.at      = at;
  end

  oal_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .value   (val_q),
    .count   (count),
    .rd_idx  (pos_low),
    .found   (found),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (take) state_next = S_CMP;
      S_CMP:   state_next = S_EXE;
      S_EXE: begin
        if (take) begin
          state_next = S_CMP;
        end else if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        count  <= count_next;
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // request and response payload
  always_ff @(posedge clk) begin
    if (take) begin
      act_q <= action_t'(req.action);
      pos_q <= req.position;
      val_q <= req.value;
    end
    if (finish) begin
      status_q <= status_next;
      len_q    <= OUT_LEN_W'(count_next);
      data_q   <= data_next;
    end
  end

  assign rsp.valid       = ovalid;
  assign rsp.status      = status_q;
  assign rsp.list_length = len_q;
  assign rsp.read_data   = data_q;

  // the list never outgrows its cells
  a_cap: assert property (@(posedge clk) disable iff (rst)
    count <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  // a taken request always goes to the compare cycle next
  a_seq: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == S_CMP))
    else $error("request not followed by compare");

  // a stalled commit keeps the list length and waits
  a_stall: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXE) && !finish) |=> ((state == S_EXE) && (count == $past(count))))
    else $error("list changed while result stalled");

  // a successful delete shortens the list by one
  a_del: assert property (@(posedge clk) disable iff (rst)
    (finish && (act_q == ACT_DELETE) && found) |=> (count == $past(count) - LEN_W'(1)))
    else $error("delete length mismatch");

endmodule
`default_nettype wire
